// File: hw/rtl/dad_pkg.sv
// Package: types, microcode table and calendar helpers for date_add_days.
package dad_pkg;

  localparam int MAX_OFFSET_DEF = 65535;
  localparam int OFF_W          = 17;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 14;

  localparam logic [4:0]  DAY_RESET   = 5'd1;
  localparam logic [3:0]  MONTH_RESET = 4'd1;
  localparam logic [13:0] YEAR_RESET  = 14'd2000;
  localparam logic [3:0]  MONTH_JAN   = 4'd1;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_DEC   = 4'd12;
  localparam logic [13:0] YEAR_MIN    = 14'd1;
  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [4:0]  LEN_31      = 5'd31;
  localparam logic [4:0]  LEN_30      = 5'd30;
  localparam logic [4:0]  LEN_29      = 5'd29;
  localparam logic [4:0]  LEN_28      = 5'd28;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_DAY   = 2'd0,
    CFG_START_MONTH = 2'd1,
    CFG_START_YEAR  = 2'd2
  } dad_cfg_e;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_LOAD = 3'd1,
    OP_FWD  = 3'd2,
    OP_BWD  = 3'd3,
    OP_EMIT = 3'd4
  } dad_op_e;

  typedef enum logic [2:0] {
    CND_ALWAYS   = 3'd0,
    CND_IN_VALID = 3'd1,
    CND_DAY_GT   = 3'd2,
    CND_DAY_LT1  = 3'd3,
    CND_OUT_FREE = 3'd4
  } dad_cond_e;

  typedef logic [2:0] dad_pc_t;

  localparam dad_pc_t PC_IDLE   = 3'd0;
  localparam dad_pc_t PC_SETTLE = 3'd1;
  localparam dad_pc_t PC_FWD    = 3'd2;
  localparam dad_pc_t PC_BWD    = 3'd3;
  localparam dad_pc_t PC_EMIT   = 3'd4;

  typedef struct packed {
    dad_op_e   op;
    dad_cond_e cond;
    dad_pc_t   tgt_true;
    dad_pc_t   tgt_false;
  } dad_cw_t;

  // control from sequencer to datapath
  typedef struct packed {
    dad_op_e op;
    logic    en;
    logic    idle;
  } dad_ctl_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic day_gt;
    logic day_lt1;
    logic out_free;
  } dad_stat_t;

  function automatic dad_cw_t ucode(input dad_pc_t pc);
    dad_cw_t cw;
    case (pc)
      PC_IDLE:   cw = '{OP_LOAD, CND_IN_VALID, PC_SETTLE, PC_IDLE};
      PC_SETTLE: cw = '{OP_NONE, CND_ALWAYS,   PC_FWD,    PC_FWD};
      PC_FWD:    cw = '{OP_FWD,  CND_DAY_GT,   PC_FWD,    PC_BWD};
      PC_BWD:    cw = '{OP_BWD,  CND_DAY_LT1,  PC_BWD,    PC_EMIT};
      PC_EMIT:   cw = '{OP_EMIT, CND_OUT_FREE, PC_IDLE,   PC_EMIT};
      default:   cw = '{OP_NONE, CND_ALWAYS,   PC_IDLE,   PC_IDLE};
    endcase
    return cw;
  endfunction

  // leap: 4 | y and (25 does not divide y, or 16 | y)
  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] prod;
    logic [13:0] q;
    logic [13:0] r;
    prod = {14'd0, y} * 28'd2621;
    q    = {2'b00, prod[27:16]};
    r    = y - 14'(q * 14'd25);
    if (r >= 14'd25) begin
      r = r - 14'd25;
    end
    return (y[1:0] == 2'b00) && ((r != 14'd0) || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      MONTH_FEB:                  len = leap ? LEN_29 : LEN_28;
      4'd4, 4'd6, 4'd9, 4'd11:    len = LEN_30;
      default:                    len = LEN_31;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/date_add_days.sv
// Top level: adds a signed day offset to a configured Gregorian date.
//
//  channel  | direction | transfer carries
//  s_axis   | in        | tdata: day_offset
//  m_axis   | out       | tdata: result_day, result_month, result_year; tuser: out_of_range
//  cfg      | in        | cfg_index_i, cfg_data_i (register write)
//
// An item is loaded in the idle step and then passes the settle step, the forward
// and backward month-step loops of the microcode and the emit step, which waits
// for the output register to be free. Reset clears the step counter, the output
// valid and the start date (2000-01-01). A result waits in the output register
// while m_axis_tready is low; the next item is taken once it has been handed to
// that register.
module date_add_days #(
  parameter int MaxOffset = dad_pkg::MAX_OFFSET_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // [16:0] day_offset
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,  // [4:0] result_day, [8:5] result_month,
                                                        // [22:9] result_year
  output logic                           m_axis_tuser,  // [0] out_of_range
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dad_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dad_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dad_pkg::*;

  dad_ctl_t    ctl;
  dad_stat_t   stat;
  logic [4:0]  res_day;
  logic [3:0]  res_month;
  logic [13:0] res_year;
  logic        res_flag;

  dad_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  dad_datapath #(
    .MaxOffset (MaxOffset)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .offset_i    (s_axis_tdata[OFF_W-1:0]),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .res_day_o   (res_day),
    .res_month_o (res_month),
    .res_year_o  (res_year),
    .res_flag_o  (res_flag)
  );

  assign s_axis_tready = ctl.idle;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tdata  = {1'b0, res_year, res_month, res_day};
  assign m_axis_tuser  = res_flag;

endmodule

// File: hw/rtl/dad_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module dad_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  dad_pkg::dad_stat_t stat_i,
  output dad_pkg::dad_ctl_t  ctl_o
);
  import dad_pkg::*;

  dad_pc_t pc_q, pc_d;
  dad_cw_t cw;
  logic    cond;

  always_comb begin
    cw = ucode(pc_q);
    case (cw.cond)
      CND_ALWAYS:   cond = 1'b1;
      CND_IN_VALID: cond = in_valid_i;
      CND_DAY_GT:   cond = stat_i.day_gt;
      CND_DAY_LT1:  cond = stat_i.day_lt1;
      CND_OUT_FREE: cond = stat_i.out_free;
      default:      cond = 1'b0;
    endcase
    pc_d = cond ? cw.tgt_true : cw.tgt_false;
  end

  assign ctl_o.op   = cw.op;
  assign ctl_o.en   = cond;
  assign ctl_o.idle = (pc_q == PC_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// File: hw/rtl/dad_datapath.sv
// Datapath: config registers, day/month/year walk registers, output register.
module dad_datapath #(
  parameter int MaxOffset = dad_pkg::MAX_OFFSET_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dad_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dad_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic signed [dad_pkg::OFF_W-1:0] offset_i,
  input  dad_pkg::dad_ctl_t               ctl_i,
  output dad_pkg::dad_stat_t              stat_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [4:0]                      res_day_o,
  output logic [3:0]                      res_month_o,
  output logic [13:0]                     res_year_o,
  output logic                            res_flag_o
);
  import dad_pkg::*;

  localparam int DayRaw = $clog2(MaxOffset + 32) + 2;
  localparam int DayW   = (DayRaw > OFF_W + 1) ? DayRaw : OFF_W + 1;
  localparam logic signed [DayW-1:0] MaxOff = DayW'(MaxOffset);

  logic [4:0]  start_day_q;
  logic [3:0]  start_month_q;
  logic [13:0] start_year_q;

  logic signed [DayW-1:0] day_q;
  logic [3:0]  m_q;
  logic [13:0] y_q;
  logic        flag_q;
  logic        leap_q;

  logic        out_valid_q;
  logic [4:0]  res_day_q;
  logic [3:0]  res_month_q;
  logic [13:0] res_year_q;
  logic        res_flag_q;

  logic signed [DayW-1:0] off_ext, off_sat;
  logic [3:0]  m_clamp;
  logic [13:0] y_clamp;
  logic [4:0]  len_cur, len_prev;
  logic        emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_day_q   <= DAY_RESET;
      start_month_q <= MONTH_RESET;
      start_year_q  <= YEAR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_DAY:   start_day_q   <= cfg_data_i[4:0];
        CFG_START_MONTH: start_month_q <= cfg_data_i[3:0];
        CFG_START_YEAR:  start_year_q  <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  always_comb begin
    off_ext = DayW'(offset_i);
    if (off_ext > MaxOff) begin
      off_sat = MaxOff;
    end else if (off_ext < -MaxOff) begin
      off_sat = -MaxOff;
    end else begin
      off_sat = off_ext;
    end
    if (start_month_q < MONTH_JAN) begin
      m_clamp = MONTH_JAN;
    end else if (start_month_q > MONTH_DEC) begin
      m_clamp = MONTH_DEC;
    end else begin
      m_clamp = start_month_q;
    end
    if (start_year_q < YEAR_MIN) begin
      y_clamp = YEAR_MIN;
    end else if (start_year_q > YEAR_MAX) begin
      y_clamp = YEAR_MAX;
    end else begin
      y_clamp = start_year_q;
    end
    len_cur  = month_len(m_q, leap_q);
    len_prev = month_len(m_q - 4'd1, leap_q);
  end

  assign stat_o.day_gt   = day_q > $signed({{(DayW-5){1'b0}}, len_cur});
  assign stat_o.day_lt1  = day_q[DayW-1] || (day_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // leap bit is registered from y_q; only read while m_q is February, or March for len_prev
  always_ff @(posedge clk_i) begin
    leap_q <= is_leap(y_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      case (ctl_i.op)
        OP_LOAD: begin
          day_q  <= $signed({{(DayW-5){1'b0}}, start_day_q}) + off_sat;
          m_q    <= m_clamp;
          y_q    <= y_clamp;
          flag_q <= 1'b0;
        end
        OP_FWD: begin
          if (m_q == MONTH_DEC) begin
            if (y_q == YEAR_MAX) begin
              flag_q <= 1'b1;
              day_q  <= DayW'(LEN_31);
            end else begin
              day_q <= day_q - $signed({{(DayW-5){1'b0}}, len_cur});
              m_q   <= MONTH_JAN;
              y_q   <= y_q + 14'd1;
            end
          end else begin
            day_q <= day_q - $signed({{(DayW-5){1'b0}}, len_cur});
            m_q   <= m_q + 4'd1;
          end
        end
        OP_BWD: begin
          if (m_q == MONTH_JAN) begin
            if (y_q == YEAR_MIN) begin
              flag_q <= 1'b1;
              day_q  <= DayW'(1);
            end else begin
              day_q <= day_q + $signed({{(DayW-5){1'b0}}, LEN_31});
              m_q   <= MONTH_DEC;
              y_q   <= y_q - 14'd1;
            end
          end else begin
            day_q <= day_q + $signed({{(DayW-5){1'b0}}, len_prev});
            m_q   <= m_q - 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign emit = ctl_i.en && (ctl_i.op == OP_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_day_q   <= day_q[4:0];
      res_month_q <= m_q;
      res_year_q  <= y_q;
      res_flag_q  <= flag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_day_o   = res_day_q;
  assign res_month_o = res_month_q;
  assign res_year_o  = res_year_q;
  assign res_flag_o  = res_flag_q;

endmodule
